FILE: rtl/core/sspg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sspg_pkg;

    // channel slots carried by the ports
    localparam int SLOTS = 8;
    localparam int CH_W = 3;
    localparam int SLOT_W = 4;
    localparam int TICK_W = 16;

    localparam logic [TICK_W-1:0] END_MAX = 16'hFFFF;
    localparam logic [TICK_W-1:0] FRAME_RESET = 16'd20000;

    // request codes
    typedef enum logic [1:0] {
        REQ_TICK    = 2'd0,
        REQ_WIDTH   = 2'd1,
        REQ_ENABLE  = 2'd2,
        REQ_DISABLE = 2'd3
    } req_t;

    // one result word
    typedef struct packed {
        logic [SLOTS-1:0] pin_levels;
        logic [CH_W-1:0]  active_channel;
        logic             pulse_active;
        logic             frame_start;
        logic             running;
    } res_t;

endpackage

`default_nettype wire

FILE: rtl/core/sspg_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sspg_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [2:0]  channel;
    logic [15:0] pulse_width;

    modport source (output valid, output req_type, output channel, output pulse_width,
                    input ready);
    modport sink (input valid, input req_type, input channel, input pulse_width,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/core/sspg_res_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sspg_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] pin_levels;
    logic [2:0] active_channel;
    logic       pulse_active;
    logic       frame_start;
    logic       running;

    modport source (output valid, output pin_levels, output active_channel,
                    output pulse_active, output frame_start, output running,
                    input ready);
    modport sink (input valid, input pin_levels, input active_channel,
                  input pulse_active, input frame_start, input running,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/core/sspg_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sspg_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] frame_ticks;

    modport source (output valid, output frame_ticks, input ready);
    modport sink (input valid, input frame_ticks, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/sequential_servo_pulse_generator_core.sv
// Sequential servo pulse generator.
// req channel: one word per request (tick, width write, enable, disable).
// res channel: one status word per accepted request, in order: pin levels,
//   active channel, pulse flag, frame start flag, running flag.
// cfg channel: writes the frame length in ticks; always ready. The user must
//   write it only while the block is idle; the block itself does not enforce this.
// Throughput: one request per cycle while req.ready is high. The status word
//   is registered in the output register, or in the skid word while res stalls.
// The channel widths sit in an 8-entry synchronous memory. A pulse start
//   reads the width; the pulse end is formed from the read data in the
//   following cycle, so a tick right behind a start still sees it.
// Stall: an output register plus one skid word; req.ready drops only while
//   the skid word is full, and no status word is lost.
// Reset: frame length 20000, all channels disabled, widths read as zero,
//   counter stopped, no pulse active, no word pending on res.
`timescale 1ns / 1ps
`default_nettype none

module sequential_servo_pulse_generator_core #(
    parameter int CHANNELS = 8
) (
    input  wire        clk,
    input  wire        rst_n,
    sspg_req_if.sink   req,
    sspg_res_if.source res,
    sspg_cfg_if.sink   cfg
);

    localparam int SLOTS = sspg_pkg::SLOTS;
    localparam int CH_W = sspg_pkg::CH_W;
    localparam int SLOT_W = sspg_pkg::SLOT_W;
    localparam int TICK_W = sspg_pkg::TICK_W;

    // width memory and its read port
    logic [TICK_W-1:0] width_mem [SLOTS];
    logic [SLOTS-1:0]  wvalid_reg;
    logic [TICK_W-1:0] rd_data_reg;
    logic              rd_hit_reg;
    logic              rd_en;
    logic [CH_W-1:0]   rd_addr;
    logic              wr_en;

    // control state
    logic [TICK_W-1:0] frame_ticks_reg;
    logic [TICK_W-1:0] cnt_reg, cnt_next;
    logic [TICK_W-1:0] start_cnt_reg, start_cnt_next;
    logic [TICK_W-1:0] pulse_end_reg, pulse_end_next;
    logic              pend_reg, pend_next;
    logic [CH_W-1:0]   cur_reg, cur_next;
    logic              pulse_on_reg, pulse_on_next;
    logic [SLOTS-1:0]  mask_reg, mask_next;

    // output register and skid word
    sspg_pkg::res_t    out_reg, skid_reg, res_word;
    logic              out_valid_reg, skid_valid_reg;

    logic              acc, pop;
    logic [SLOTS-1:0]  chan_ok;
    logic [SLOTS-1:0]  ch_bit;
    logic              ch_valid;
    logic [TICK_W-1:0] frame_len;
    logic [TICK_W-1:0] eff_width;
    logic [TICK_W:0]   end_sum;
    logic [TICK_W-1:0] eff_end;
    logic [TICK_W:0]   cnt_inc;
    logic              start;
    logic [SLOT_W-1:0] first;
    logic              found;
    logic [CH_W-1:0]   pick;
    logic              fstart;
    sspg_pkg::req_t    req_code;

    assign acc = req.valid && req.ready;
    assign pop = out_valid_reg && res.ready;
    assign req.ready = !skid_valid_reg;
    assign cfg.ready = 1'b1;
    assign req_code = sspg_pkg::req_t'(req.req_type);

    // channels that exist in this build
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            chan_ok[i] = (i < CHANNELS);
        end
    end

    assign ch_bit = SLOTS'(1) << req.channel;
    assign ch_valid = chan_ok[req.channel];
    assign frame_len = (frame_ticks_reg == '0) ? TICK_W'(1) : frame_ticks_reg;

    // pulse end: built from the read data for a pulse started last cycle, else the stored end
    assign eff_width = (rd_hit_reg && rd_data_reg != '0) ? rd_data_reg : TICK_W'(1);
    assign end_sum = {1'b0, start_cnt_reg} + {1'b0, eff_width};
    always_comb
    begin
        if (!pend_reg)
        begin
            eff_end = pulse_end_reg;
        end
        else if (end_sum[TICK_W])
        begin
            eff_end = sspg_pkg::END_MAX;
        end
        else
        begin
            eff_end = end_sum[TICK_W-1:0];
        end
    end

    assign cnt_inc = {1'b0, cnt_reg} + (TICK_W+1)'(1);

    // request decode and next state
    always_comb
    begin
        cnt_next = cnt_reg;
        start_cnt_next = start_cnt_reg;
        pulse_end_next = eff_end;
        pend_next = 1'b0;
        cur_next = cur_reg;
        pulse_on_next = pulse_on_reg;
        mask_next = mask_reg;
        start = 1'b0;
        first = '0;
        fstart = 1'b0;
        wr_en = 1'b0;
        rd_en = 1'b0;
        rd_addr = '0;
        found = 1'b0;
        pick = '0;

        if (acc)
        begin
            case (req_code)
                sspg_pkg::REQ_TICK:
                begin
                    if (mask_reg != '0)
                    begin
                        if (cnt_inc >= {1'b0, frame_len})
                        begin
                            cnt_next = '0;
                            start = 1'b1;
                            first = '0;
                            fstart = 1'b1;
                        end
                        else
                        begin
                            cnt_next = cnt_inc[TICK_W-1:0];
                            if (pulse_on_reg && cnt_inc[TICK_W-1:0] >= eff_end)
                            begin
                                start = 1'b1;
                                first = {1'b0, cur_reg} + SLOT_W'(1);
                            end
                        end
                    end
                end
                sspg_pkg::REQ_WIDTH:
                begin
                    wr_en = ch_valid;
                end
                sspg_pkg::REQ_ENABLE:
                begin
                    if (ch_valid && (mask_reg & ch_bit) == '0)
                    begin
                        mask_next = mask_reg | ch_bit;
                        if (mask_reg == '0)
                        begin
                            cnt_next = '0;
                            start = 1'b1;
                            first = '0;
                            fstart = 1'b1;
                        end
                    end
                end
                default:
                begin
                    if (ch_valid && (mask_reg & ch_bit) != '0)
                    begin
                        mask_next = mask_reg & ~ch_bit;
                        if (mask_next == '0)
                        begin
                            cnt_next = '0;
                            pulse_end_next = '0;
                            pulse_on_next = 1'b0;
                            cur_next = '0;
                        end
                        else if (pulse_on_reg && cur_reg == req.channel)
                        begin
                            start = 1'b1;
                            first = {1'b0, req.channel} + SLOT_W'(1);
                        end
                    end
                end
            endcase
        end

        // lowest enabled channel at or above first
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!found && SLOT_W'(i) >= first && mask_next[i] && chan_ok[i])
            begin
                found = 1'b1;
                pick = CH_W'(i);
            end
        end

        // pulse start: fetch the width, end resolves next cycle
        if (start)
        begin
            pulse_on_next = found;
            if (found)
            begin
                cur_next = pick;
                rd_en = 1'b1;
                rd_addr = pick;
                pend_next = 1'b1;
                start_cnt_next = cnt_next;
            end
        end
    end

    // status word for this request
    always_comb
    begin
        res_word.pin_levels = pulse_on_next ? (SLOTS'(1) << cur_next) : '0;
        res_word.active_channel = pulse_on_next ? cur_next : '0;
        res_word.pulse_active = pulse_on_next;
        res_word.frame_start = fstart;
        res_word.running = (mask_next != '0);
    end

    // width memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            width_mem[req.channel] <= req.pulse_width;
        end
        if (rd_en)
        begin
            rd_data_reg <= width_mem[rd_addr];
            rd_hit_reg <= wvalid_reg[rd_addr];
        end
    end

    // written flags stand in for the zero reset of the widths
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wvalid_reg <= '0;
        end
        else if (wr_en)
        begin
            wvalid_reg <= wvalid_reg | ch_bit;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_ticks_reg <= sspg_pkg::FRAME_RESET;
            cnt_reg <= '0;
            start_cnt_reg <= '0;
            pulse_end_reg <= '0;
            pend_reg <= 1'b0;
            cur_reg <= '0;
            pulse_on_reg <= 1'b0;
            mask_reg <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                frame_ticks_reg <= cfg.frame_ticks;
            end
            cnt_reg <= cnt_next;
            start_cnt_reg <= start_cnt_next;
            pulse_end_reg <= pulse_end_next;
            pend_reg <= pend_next;
            cur_reg <= cur_next;
            pulse_on_reg <= pulse_on_next;
            mask_reg <= mask_next;
        end
    end

    // output register and skid word valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                if (skid_valid_reg)
                begin
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= acc;
                end
            end
            else if (acc)
            begin
                if (out_valid_reg)
                begin
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    out_valid_reg <= 1'b1;
                end
            end
        end
    end

    // output and skid payload
    always_ff @(posedge clk)
    begin
        if (pop && skid_valid_reg)
        begin
            out_reg <= skid_reg;
        end
        else if (acc && (!out_valid_reg || pop))
        begin
            out_reg <= res_word;
        end
        if (acc && out_valid_reg && !pop)
        begin
            skid_reg <= res_word;
        end
    end

    assign res.valid = out_valid_reg;
    assign res.pin_levels = out_reg.pin_levels;
    assign res.active_channel = out_reg.active_channel;
    assign res.pulse_active = out_reg.pulse_active;
    assign res.frame_start = out_reg.frame_start;
    assign res.running = out_reg.running;

endmodule

`default_nettype wire
